// ===== rtl/sil_pkg.sv =====
package sil_pkg;

	localparam logic [2:0] MODE_SORTED      = 3'd0;
	localparam logic [2:0] MODE_HEAD        = 3'd1;
	localparam logic [2:0] MODE_TAIL        = 3'd2;
	localparam logic [2:0] MODE_REMOVE_HEAD = 3'd3;
	localparam logic [2:0] MODE_REMOVE_TAIL = 3'd4;
	localparam logic [2:0] MODE_DUMP        = 3'd5;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE_HEAD,
		CELL_REMOVE_TAIL,
		CELL_ROTATE
	} cell_op_t;

	// cmp_en: insert ahead of the first greater entry; force_hit: insert at head
	typedef struct packed {
		cell_op_t op;
		logic     cmp_en;
		logic     force_hit;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

// ===== rtl/sorted_insert_list_unit.sv =====
// Inserts and removals strobe their result in the cycle after start.
// Throughput is one such item per cycle; busy stays low between them.
// Dump of n entries rotates the cell chain once per entry: its n results appear back to
// back, the first in the cycle after start, and busy is high while the rest are read out.
// The receiver cannot stall. Reset empties the list; entry contents are not cleared.
module sorted_insert_list_unit import sil_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	output logic      result_valid,
	output out_item_t result
);

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [WIDTH-1:0] ent [DEPTH+1];
	logic                    vld [DEPTH+1];
	logic signed [WIDTH-1:0] tail_ent [DEPTH];
	logic                    found [DEPTH+1];

	logic signed [WIDTH-1:0] value_w;
	logic signed [WIDTH-1:0] tail_entry;
	logic signed [31:0]      head_data;
	logic signed [31:0]      tail_data;

	cell_ctrl_t ctrl;
	state_t     state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] dump_left_q, dump_left_d;
	out_item_t  result_q, result_d;
	logic       result_valid_q, result_valid_d;
	logic       full, empty;

	assign value_w   = WIDTH'(cmd.value);
	assign head_data = 32'(ent[0]);
	assign tail_data = 32'(tail_entry);

	assign ent[DEPTH]   = '0;
	assign vld[DEPTH]   = 1'b0;
	assign found[0]     = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WIDTH-1:0] left_entry;
		logic                    left_valid;
		if (i == 0) begin : g_head
			assign left_entry = '0;
			assign left_valid = 1'b0;
		end else begin : g_body
			assign left_entry = ent[i-1];
			assign left_valid = vld[i-1];
		end
		sil_cell #(.WIDTH(WIDTH)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.value      (value_w),
			.head_entry (ent[0]),
			.left_entry (left_entry),
			.left_valid (left_valid),
			.right_entry(ent[i+1]),
			.right_valid(vld[i+1]),
			.found_in   (found[i]),
			.found_out  (found[i+1]),
			.entry      (ent[i]),
			.valid      (vld[i]),
			.tail_entry (tail_ent[i])
		);
	end

	// at most one cell flags itself as tail (none when the list is empty), so an OR picks it
	always_comb begin
		tail_entry = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_entry = tail_entry | tail_ent[i];
		end
	end

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			dump_left_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			dump_left_q    <= dump_left_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		dump_left_d    = dump_left_q;
		result_valid_d = 1'b0;
		result_d       = '0;
		ctrl           = '{op: CELL_HOLD, cmp_en: 1'b0, force_hit: 1'b0};

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					result_valid_d = 1'b1;
					result_d.last  = 1'b1;
					result_d.status = STATUS_OK;
					case (cmd.mode)
						MODE_SORTED, MODE_HEAD, MODE_TAIL: begin
							if (full) begin
								result_d.status = STATUS_FULL;
							end else begin
								ctrl.op        = CELL_INSERT;
								ctrl.cmp_en    = (cmd.mode == MODE_SORTED);
								ctrl.force_hit = (cmd.mode == MODE_HEAD);
								count_d        = count_q + 1'b1;
							end
						end
						MODE_REMOVE_HEAD, MODE_REMOVE_TAIL: begin
							if (empty) begin
								result_d.status = STATUS_EMPTY;
							end else begin
								if (cmd.mode == MODE_REMOVE_HEAD) begin
									ctrl.op       = CELL_REMOVE_HEAD;
									result_d.data = head_data;
								end else begin
									ctrl.op       = CELL_REMOVE_TAIL;
									result_d.data = tail_data;
								end
								count_d = count_q - 1'b1;
							end
						end
						MODE_DUMP: begin
							if (empty) begin
								result_d.status = STATUS_EMPTY;
							end else begin
								ctrl.op       = CELL_ROTATE;
								result_d.data = head_data;
								result_d.last = (count_q == CW'(1));
								dump_left_d   = count_q - 1'b1;
								if (count_q != CW'(1)) begin
									state_d = ST_DUMP;
								end
							end
						end
						default: ;
					endcase
					result_d.entry_count = 5'(count_d);
				end
			end
			ST_DUMP: begin
				ctrl.op              = CELL_ROTATE;
				result_valid_d       = 1'b1;
				result_d.data        = head_data;
				result_d.status      = STATUS_OK;
				result_d.entry_count = 5'(count_q);
				result_d.last        = (dump_left_q == CW'(1));
				dump_left_d          = dump_left_q - 1'b1;
				if (dump_left_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy         = (state_q == ST_DUMP);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/sil_cell.sv =====
module sil_cell import sil_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctrl_t              ctrl,
	input  logic signed [WIDTH-1:0] value,
	input  logic signed [WIDTH-1:0] head_entry,
	input  logic signed [WIDTH-1:0] left_entry,
	input  logic                    left_valid,
	input  logic signed [WIDTH-1:0] right_entry,
	input  logic                    right_valid,
	input  logic                    found_in,
	output logic                    found_out,
	output logic signed [WIDTH-1:0] entry,
	output logic                    valid,
	output logic signed [WIDTH-1:0] tail_entry
);

	logic signed [WIDTH-1:0] entry_q;
	logic                    valid_q;
	logic                    hit;

	assign hit        = !valid_q || ctrl.force_hit || (ctrl.cmp_en && (entry_q > value));
	assign found_out  = found_in || hit;
	assign entry      = entry_q;
	assign valid      = valid_q;
	assign tail_entry = (valid_q && !right_valid) ? entry_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				CELL_INSERT: begin
					if (found_in) begin
						valid_q <= left_valid;
					end else if (hit) begin
						valid_q <= 1'b1;
					end
				end
				CELL_REMOVE_HEAD: valid_q <= right_valid;
				CELL_REMOVE_TAIL: valid_q <= valid_q && right_valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				// shift right behind the insert point, take the value at it
				if (found_in) begin
					entry_q <= left_entry;
				end else if (hit) begin
					entry_q <= value;
				end
			end
			CELL_REMOVE_HEAD: entry_q <= right_entry;
			CELL_ROTATE: begin
				// tail wraps the head around; cells past the tail hold
				if (valid_q) begin
					entry_q <= right_valid ? right_entry : head_entry;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sil_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_ITEMS = 300;

	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd;
	logic      result_valid;
	out_item_t result;

	// shadow of the list, head at index 0
	logic signed [31:0] list_model[$];
	out_item_t          pending_results[$];
	int                 fail_count = 0;
	int                 quiet_cycles = 0;

	sorted_insert_list_unit #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic in_item_t make_item(logic [2:0] mode, logic signed [31:0] value);
		in_item_t item;
		item.mode = mode;
		item.value = value;
		return item;
	endfunction

	function automatic void predict_list_op(in_item_t item);
		out_item_t res;
		int pos;
		int n;
		res = '0;
		res.last = 1'b1;
		case (item.mode)
			MODE_SORTED, MODE_HEAD, MODE_TAIL: begin
				if (list_model.size() >= LIST_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					if (item.mode == MODE_HEAD) begin
						pos = 0;
					end else if (item.mode == MODE_TAIL) begin
						pos = list_model.size();
					end else begin
						// go past equal entries so ties keep arrival order
						pos = 0;
						while (pos < list_model.size() &&
							$signed(list_model[pos]) <= $signed(item.value))
							pos++;
					end
					list_model.insert(pos, item.value);
				end
				res.entry_count = 5'(list_model.size());
				pending_results.push_back(res);
			end
			MODE_REMOVE_HEAD, MODE_REMOVE_TAIL: begin
				if (list_model.size() == 0)
					res.status = STATUS_EMPTY;
				else if (item.mode == MODE_REMOVE_HEAD)
					res.data = list_model.pop_front();
				else
					res.data = list_model.pop_back();
				res.entry_count = 5'(list_model.size());
				pending_results.push_back(res);
			end
			MODE_DUMP: begin
				n = list_model.size();
				if (n == 0) begin
					res.status = STATUS_EMPTY;
					pending_results.push_back(res);
				end else begin
					for (int i = 0; i < n; i++) begin
						res.data = list_model[i];
						res.entry_count = 5'(n);
						res.last = (i == n - 1);
						pending_results.push_back(res);
					end
				end
			end
			default: begin
				res.entry_count = 5'(list_model.size());
				pending_results.push_back(res);
			end
		endcase
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	function automatic void compare_result(out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result with none expected, expected none, actual %p", $time, got);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		check_field("data", want.data, got.data);
		check_field("status", 32'(want.status), 32'(got.status));
		check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		check_field("last", 32'(want.last), 32'(got.last));
	endfunction

	// check results first, then predict: a result never belongs to the item taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				compare_result(result);
			if (start && !busy)
				predict_list_op(cmd);
			if (result_valid || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// hold the item until taken; start is left high for a following item
	task automatic send_item(in_item_t item);
		@(negedge clk);
		start <= 1'b1;
		cmd <= item;
		do
			@(posedge clk);
		while (busy);
	endtask

	// drop start and scribble on the command bus while idle
	task automatic idle_gap(int cycles);
		in_item_t noise;
		repeat (cycles) begin
			noise.mode = 3'($urandom_range(0, 7));
			noise.value = $urandom();
			@(negedge clk);
			start <= 1'b0;
			cmd <= noise;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] random_value();
		int k;
		case ($urandom_range(0, 3))
			0: begin
				k = $urandom_range(0, 8);
				return k - 4;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic in_item_t random_item(int grow_pct);
		int pick;
		logic [2:0] mode;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		else if (pick < 10)
			mode = MODE_DUMP;
		else if (pick < 10 + grow_pct * 9 / 10)
			mode = ($urandom_range(0, 9) < 6) ? MODE_SORTED :
				($urandom_range(0, 1) ? MODE_HEAD : MODE_TAIL);
		else
			mode = $urandom_range(0, 1) ? MODE_REMOVE_HEAD : MODE_REMOVE_TAIL;
		return make_item(mode, random_value());
	endfunction

	task automatic test_empty_list();
		send_item(make_item(MODE_DUMP, VAL_MAX));
		send_item(make_item(MODE_REMOVE_HEAD, -32'sd1));
		send_item(make_item(MODE_REMOVE_TAIL, VAL_MIN));
	endtask

	task automatic test_every_mode();
		send_item(make_item(MODE_SORTED, 32'sd0));
		send_item(make_item(MODE_SORTED, VAL_MAX));
		send_item(make_item(MODE_SORTED, VAL_MIN));
		send_item(make_item(MODE_SORTED, -32'sd1));
		send_item(make_item(MODE_SORTED, 32'sd1));
		send_item(make_item(MODE_SORTED, 32'sd0));
		send_item(make_item(MODE_HEAD, 32'sd5));
		send_item(make_item(MODE_TAIL, -32'sd5));
		send_item(make_item(MODE_SPARE_LO, 32'sd0));
		send_item(make_item(MODE_SPARE_HI, -32'sd1));
		send_item(make_item(MODE_DUMP, 32'sd0));
		send_item(make_item(MODE_REMOVE_HEAD, 32'sd0));
		send_item(make_item(MODE_REMOVE_TAIL, 32'sd0));
		send_item(make_item(MODE_DUMP, -32'sd1));
	endtask

	task automatic test_full_list();
		int room;
		wait_drained();
		room = LIST_DEPTH - list_model.size();
		repeat (room)
			send_item(make_item(MODE_SORTED, random_value()));
		send_item(make_item(MODE_SORTED, random_value()));
		send_item(make_item(MODE_HEAD, random_value()));
		send_item(make_item(MODE_TAIL, random_value()));
		idle_gap($urandom_range(1, 3));
		send_item(make_item(MODE_DUMP, random_value()));
		repeat (LIST_DEPTH)
			send_item(make_item($urandom_range(0, 1) ? MODE_REMOVE_HEAD : MODE_REMOVE_TAIL,
				random_value()));
		send_item(make_item(MODE_REMOVE_TAIL, random_value()));
		send_item(make_item(MODE_DUMP, random_value()));
	endtask

	task automatic test_random_traffic(int n_items);
		int sent;
		int burst;
		int grow_pct;
		sent = 0;
		grow_pct = 70;
		while (sent < n_items) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
			repeat (burst) begin
				// swing between filling and draining so both ends get visited
				if ($urandom_range(0, 19) == 0)
					grow_pct = $urandom_range(0, 1) ? 85 : 25;
				send_item(random_item(grow_pct));
				sent++;
			end
			idle_gap($urandom_range(1, 6));
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_every_mode();
		test_full_list();
		test_random_traffic(RANDOM_ITEMS);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
